### hw/rtl/sept_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sept_pkg: shared types and constants of the sorted envelope point table
// Word layouts for command and response, the stored point, action and status
// codes, and the request that drives the marker fixup unit.
// ----------------------------------------------------------------------------
package sept_pkg;

	localparam int MAX_POINTS = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Fill count of a full table, and the marker code for "no point"
	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] MARK_NONE = CNT_W'(MAX_POINTS);

	// Action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_MOVE   = 2'd2;
	localparam logic [1:0] ACT_MARKER = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  point_index;
		logic [15:0] point_time;
		logic [15:0] point_level;
		logic [1:0]  marker_select;
		logic [5:0]  marker_position;
	} cmd_t;

	typedef struct packed {
		logic [4:0] result_index;
		logic [1:0] status;
		logic [5:0] points_held;
		logic [5:0] sustain_first;
		logic [5:0] sustain_last;
		logic [5:0] loop_first;
		logic [5:0] loop_last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] tick;
		logic [15:0] level;
	} point_t;

	// Marker fixup operations
	typedef enum logic [2:0] {
		MOP_INSERT,
		MOP_DELETE,
		MOP_BACK,
		MOP_FWD,
		MOP_SET
	} mark_op_t;

	typedef struct packed {
		logic             valid;
		mark_op_t         op;
		logic [CNT_W-1:0] old_idx;
		logic [CNT_W-1:0] new_idx;
		logic [1:0]       sel;
		logic [CNT_W-1:0] pos;
	} mark_req_t;

endpackage

### hw/rtl/sept_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sept_store: point memory
// One write port and one read port with registered read data. Holds the
// (time, level) pairs of the table in index order.
// ----------------------------------------------------------------------------
module sept_store
	import sept_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  point_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output point_t           rd_data
);

	point_t mem_q [MAX_POINTS];

	// write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// register the read word
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

### hw/rtl/sept_marks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sept_marks: marker registers and fixup
// Holds sustain begin/end and loop start/end, and shifts or clears them after
// an insert, delete or move so that they keep naming the same points, and set one on a marker set.
// ----------------------------------------------------------------------------
module sept_marks
	import sept_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  mark_req_t                  req,
	output logic [3:0][CNT_W-1:0]      marks
);

	logic [3:0][CNT_W-1:0] marks_q;
	logic [3:0][CNT_W-1:0] marks_d;
	logic [1:0]            pair_hit;

	// a delete that hits either end of a pair clears the whole pair
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			pair_hit[p] = (marks_q[2*p] == req.old_idx) || (marks_q[2*p+1] == req.old_idx);
		end
	end

	// work out the adjusted markers
	always_comb begin
		marks_d = marks_q;
		if (req.valid) begin
			unique case (req.op)
				MOP_INSERT: begin
					for (int m = 0; m < 4; m++) begin
						if (marks_q[m] != MARK_NONE && marks_q[m] >= req.new_idx) begin
							marks_d[m] = marks_q[m] + CNT_W'(1);
						end
					end
				end
				MOP_DELETE: begin
					for (int m = 0; m < 4; m++) begin
						if (pair_hit[m/2]) begin
							marks_d[m] = MARK_NONE;
						end else if (marks_q[m] != MARK_NONE && marks_q[m] > req.old_idx) begin
							marks_d[m] = marks_q[m] - CNT_W'(1);
						end
					end
				end
				MOP_BACK: begin
					for (int m = 0; m < 4; m++) begin
						if (marks_q[m] != MARK_NONE && marks_q[m] >= req.new_idx
								&& marks_q[m] < req.old_idx) begin
							marks_d[m] = marks_q[m] + CNT_W'(1);
						end
					end
				end
				MOP_FWD: begin
					for (int m = 0; m < 4; m++) begin
						if (marks_q[m] != MARK_NONE && marks_q[m] > req.old_idx
								&& marks_q[m] <= req.new_idx) begin
							marks_d[m] = marks_q[m] - CNT_W'(1);
						end
					end
				end
				MOP_SET: begin
					marks_d[req.sel] = req.pos;
				end
				default: begin
					marks_d = marks_q;
				end
			endcase
		end
	end

	// hold the markers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= {4{MARK_NONE}};
		end else begin
			marks_q <= marks_d;
		end
	end

	assign marks = marks_q;

	// a marker is either none or names a table slot
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(marks_q[0] <= MARK_NONE) && (marks_q[1] <= MARK_NONE)
		&& (marks_q[2] <= MARK_NONE) && (marks_q[3] <= MARK_NONE))
		else $error("marker beyond table");

endmodule

### hw/rtl/sorted_envelope_point_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_envelope_point_table: time-sorted envelope point table with markers
// Insert, delete, move and marker-set commands on a table of up to 32 points.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the command's response is ready. One compare-and-shift unit walks
// the point memory one entry per cycle for an insert, delete or move, shifting
// at most 31 entries; a move first checks its neighbors. The response word is
// on rsp for the single cycle that done is high and must be taken then; busy is
// already low in that cycle, so the next command can be started while the
// response is shown.
// ----------------------------------------------------------------------------
module sorted_envelope_point_table
	import sept_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_CHK_PREV,
		S_CHK_NEXT,
		S_WALK_DN,
		S_WALK_UP,
		S_FIX,
		S_RESP
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [IDX_W-1:0]      j_q;
	logic [CNT_W-1:0]      fill_q;
	logic [1:0]            status_q;
	logic                  up_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	point_t                wr_data;
	logic [IDX_W-1:0]      rd_addr;
	point_t                rd_pt;
	point_t                new_pt;
	logic [CNT_W-1:0]      j_ext;
	logic [CNT_W-1:0]      j_nxt_ext;
	logic                  is_move;
	logic                  is_del;
	logic                  dn_cont;
	logic                  up_cont;
	logic                  back_go;
	logic                  fwd_go;
	logic                  cmd_ok;
	mark_req_t             mreq;
	logic [3:0][CNT_W-1:0] marks;

	sept_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_pt)
	);

	sept_marks u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.marks  (marks)
	);

	// compare unit: decisions on the word read last cycle
	assign new_pt    = '{tick: cmd_q.point_time, level: cmd_q.point_level};
	assign j_ext     = {1'b0, j_q};
	assign j_nxt_ext = j_ext + CNT_W'(1);
	assign is_move   = (cmd_q.action == ACT_MOVE);
	assign is_del    = (cmd_q.action == ACT_DELETE);
	assign dn_cont   = (j_q != '0) && ((rd_pt.tick > cmd_q.point_time)
		|| (is_move && rd_pt.tick == cmd_q.point_time));
	assign up_cont   = (j_nxt_ext < fill_q) && (is_del || rd_pt.tick <= cmd_q.point_time);
	assign back_go   = (j_q != '0) && (rd_pt.tick > cmd_q.point_time);
	assign fwd_go    = (j_nxt_ext < fill_q) && (rd_pt.tick < cmd_q.point_time);
	assign cmd_ok    = (status_q == ST_OK);

	// memory addressing: read one entry ahead of the slot being written
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = j_q;
		wr_data = new_pt;
		rd_addr = j_q - IDX_W'(1);
		unique case (state_q)
			S_PREP: begin
				unique case (cmd_q.action)
					ACT_DELETE: rd_addr = j_q + IDX_W'(1);
					ACT_INSERT,
					ACT_MOVE:   rd_addr = j_q - IDX_W'(1);
					default:    rd_addr = j_q;
				endcase
			end
			S_CHK_PREV: begin
				rd_addr = back_go ? (j_q - IDX_W'(1)) : (j_q + IDX_W'(1));
			end
			S_CHK_NEXT: begin
				rd_addr = j_q + IDX_W'(1);
				wr_en   = !fwd_go;
			end
			S_WALK_DN: begin
				rd_addr = j_q - IDX_W'(2);
				wr_en   = 1'b1;
				wr_data = dn_cont ? rd_pt : new_pt;
			end
			S_WALK_UP: begin
				rd_addr = j_q + IDX_W'(2);
				wr_en   = up_cont || !is_del;
				wr_data = up_cont ? rd_pt : new_pt;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// marker fixup request, issued once at the end of an accepted command
	always_comb begin
		mreq.valid   = (state_q == S_FIX);
		mreq.old_idx = {1'b0, cmd_q.point_index};
		mreq.new_idx = j_ext;
		mreq.sel     = cmd_q.marker_select;
		mreq.pos     = cmd_q.marker_position;
		unique case (cmd_q.action)
			ACT_INSERT: mreq.op = MOP_INSERT;
			ACT_DELETE: mreq.op = MOP_DELETE;
			ACT_MOVE:   mreq.op = up_q ? MOP_FWD : MOP_BACK;
			default:    mreq.op = MOP_SET;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			j_q      <= '0;
			fill_q   <= '0;
			status_q <= ST_OK;
			up_q     <= 1'b0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= (state_q == S_RESP);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						up_q  <= 1'b0;
						j_q   <= (cmd.action == ACT_INSERT) ? fill_q[IDX_W-1:0]
							: cmd.point_index;
						unique case (cmd.action)
							ACT_INSERT: begin
								if (fill_q == MAX_CNT) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_PREP;
								end
							end
							ACT_DELETE,
							ACT_MOVE: begin
								if ({1'b0, cmd.point_index} >= fill_q) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_PREP;
								end
							end
							default: begin
								if (cmd.marker_position == MARK_NONE
										|| cmd.marker_position < fill_q) begin
									status_q <= ST_OK;
									state_q  <= S_FIX;
								end else begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end
							end
						endcase
					end
				end
				S_PREP: begin
					unique case (cmd_q.action)
						ACT_INSERT: state_q <= S_WALK_DN;
						ACT_DELETE: state_q <= S_WALK_UP;
						ACT_MOVE:   state_q <= S_CHK_PREV;
						default:    state_q <= S_FIX;
					endcase
				end
				S_CHK_PREV: begin
					state_q <= back_go ? S_WALK_DN : S_CHK_NEXT;
				end
				S_CHK_NEXT: begin
					if (fwd_go) begin
						up_q    <= 1'b1;
						state_q <= S_WALK_UP;
					end else begin
						state_q <= S_FIX;
					end
				end
				S_WALK_DN: begin
					if (dn_cont) begin
						j_q <= j_q - IDX_W'(1);
					end else begin
						state_q <= S_FIX;
					end
				end
				S_WALK_UP: begin
					if (up_cont) begin
						j_q <= j_q + IDX_W'(1);
					end else begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (cmd_q.action == ACT_INSERT) begin
						fill_q <= fill_q + CNT_W'(1);
					end else if (cmd_q.action == ACT_DELETE) begin
						fill_q <= fill_q - CNT_W'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					rsp_q.result_index  <= (cmd_ok && (cmd_q.action == ACT_INSERT || is_move))
						? j_q : '0;
					rsp_q.status        <= status_q;
					rsp_q.points_held   <= fill_q;
					rsp_q.sustain_first <= marks[0];
					rsp_q.sustain_last  <= marks[1];
					rsp_q.loop_first    <= marks[2];
					rsp_q.loop_last     <= marks[3];
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// the strobe follows the response state and nothing else
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_RESP))
		else $error("done without response state");

	// the fill count never passes the table size
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_CNT)
		else $error("fill count overflow");

	// the memory is written only while a command is in progress
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> busy)
		else $error("memory write while idle");

	// an upward walk stays inside the filled part of the table
	a_walk_up: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK_UP) |-> (j_ext < fill_q))
		else $error("upward walk beyond fill");

endmodule
